### rtl/core/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// Types, register indexes and arithmetic helpers shared by the 3x3 filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

   localparam int unsigned SUM_W  = 28;   // exact signed 9-tap sum, 8 fraction bits
   localparam int unsigned PROD_W = 53;   // sum times unsigned Q8.16 reciprocal
   localparam int unsigned FRAC_W = 24;
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPW    = 2;
   localparam int unsigned TAPS   = 9;
   localparam int unsigned CHANS  = 4;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_CTOP   = 3'd2;
   localparam logic [2:0] REG_CMID   = 3'd3;
   localparam logic [2:0] REG_CBOT   = 3'd4;
   localparam logic [2:0] REG_RECIP  = 3'd5;
   localparam logic [2:0] REG_BIAS   = 3'd6;

   typedef logic [31:0] pixel_type;   // A 31:24, R 23:16, G 15:8, B 7:0

   typedef struct packed {
      pixel_type [TAPS-1:0] win;
      logic [11:0]          col;
      logic [11:0]          row;
      logic                 last;
   } win_entry_type;

   typedef struct packed {
      logic [47:0] top;
      logic [47:0] mid;
      logic [47:0] bot;
      logic [23:0] recip;
      logic [9:0]  bias;
   } coeff_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MAC,
      B_SCALE,
      B_DONE
   } back_state_type;

   function automatic logic signed [15:0] tap_of(coeff_type cf, logic [3:0] k);
      logic [15:0] raw;
      unique case (k)
         4'd0: raw = cf.top[15:0];
         4'd1: raw = cf.top[31:16];
         4'd2: raw = cf.top[47:32];
         4'd3: raw = cf.mid[15:0];
         4'd4: raw = cf.mid[31:16];
         4'd5: raw = cf.mid[47:32];
         4'd6: raw = cf.bot[15:0];
         4'd7: raw = cf.bot[31:16];
         4'd8: raw = cf.bot[47:32];
         default: raw = 16'd0;
      endcase
      return $signed(raw);
   endfunction

   // truncate toward zero, add bias, clamp to a byte
   function automatic logic [7:0] finish_chan(logic signed [PROD_W-1:0] p,
                                              logic [9:0] bias);
      logic signed [PROD_W-1:0]        adj;
      logic signed [PROD_W-FRAC_W-1:0] v;
      logic signed [PROD_W-FRAC_W:0]   s;
      adj = p + (p[PROD_W-1] ? $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
                             : $signed({PROD_W{1'b0}}));
      v   = adj[PROD_W-1:FRAC_W];
      s   = {v[PROD_W-FRAC_W-1], v}
          + $signed({{(PROD_W-FRAC_W-9){bias[9]}}, bias});
      if (s[PROD_W-FRAC_W]) begin
         return 8'd0;
      end else if (s > $signed({{(PROD_W-FRAC_W-7){1'b0}}, 8'hFF})) begin
         return 8'hFF;
      end
      return s[7:0];
   endfunction

endpackage

### rtl/core/c3f_ram.sv
// ----------------------------------------------------------------------------
// c3f_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module c3f_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/c3f_front.sv
// ----------------------------------------------------------------------------
// c3f_front
// Takes pixels, keeps the line stores and the 3x3 window, tracks the raster
// position and hands complete interior windows to the queue.
// ----------------------------------------------------------------------------
module c3f_front #(
   parameter int unsigned MAX_WIDTH = 4096,
   parameter int unsigned CW        = $clog2(MAX_WIDTH),
   parameter int unsigned WW        = (CW + 1 > 13) ? CW + 1 : 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  c3f_pkg::pixel_type     req_pixel,
   input  logic [WW-1:0]          width_lim,
   input  logic [12:0]            height_lim,
   input  logic                   q_almost_full,
   output logic                   push_valid,
   output c3f_pkg::win_entry_type push_entry
);
   import c3f_pkg::*;

   logic [CW-1:0]  col_ff, col_in;
   logic [11:0]    row_ff, row_in;
   logic           accept;
   logic           s2_valid_ff, s2_emit_ff, s2_last_ff;
   logic [CW-1:0]  s2_col_ff;
   logic [11:0]    s2_ocol_ff, s2_orow_ff;
   pixel_type      s2_px_ff;
   pixel_type      up1, up2;
   pixel_type [TAPS-1:0] win_ff, win_in;
   logic           col_wrap, row_wrap;
   logic [WW-1:0]  col_next;
   logic [12:0]    row_next;

   assign req_ready = !q_almost_full;
   assign accept    = req_valid && req_ready;
   assign col_next  = WW'(col_ff) + WW'(1);
   assign row_next  = {1'b0, row_ff} + 13'd1;
   assign col_wrap  = col_next >= width_lim;
   assign row_wrap  = row_next >= height_lim;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? 12'd0 : row_next[11:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   c3f_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (s2_px_ff),
      .rd_addr (col_ff),
      .rd_data (up1)
   );

   c3f_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (up1),
      .rd_addr (col_ff),
      .rd_data (up2)
   );

   // shift each window row left, new column enters on the right
   always_comb begin
      win_in = win_ff;
      if (s2_valid_ff) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = up2;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = up1;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s2_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s2_valid_ff <= accept;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_px_ff   <= req_pixel;
         s2_col_ff  <= col_ff;
         s2_emit_ff <= (row_ff >= 12'd2) && (col_ff >= CW'(2));
         s2_last_ff <= col_wrap && row_wrap;
         s2_ocol_ff <= 12'(col_ff - CW'(1));
         s2_orow_ff <= row_ff - 12'd1;
      end
   end

   assign push_valid      = s2_valid_ff && s2_emit_ff;
   assign push_entry.win  = win_in;
   assign push_entry.col  = s2_ocol_ff;
   assign push_entry.row  = s2_orow_ff;
   assign push_entry.last = s2_last_ff;

endmodule

### rtl/core/c3f_queue.sv
// ----------------------------------------------------------------------------
// c3f_queue
// Short window queue between the front and the back.
// ----------------------------------------------------------------------------
module c3f_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  c3f_pkg::win_entry_type push_entry,
   output logic                   almost_full,
   output logic                   pop_valid,
   input  logic                   pop,
   output c3f_pkg::win_entry_type pop_entry
);
   import c3f_pkg::*;

   win_entry_type entry_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPW:0]   count_ff;
   logic           do_pop;

   assign do_pop      = pop && pop_valid;
   assign pop_valid   = count_ff != '0;
   assign pop_entry   = entry_ff[rd_ptr_ff];
   // keep one slot for the window still in the front's second stage
   assign almost_full = count_ff >= (QPW+1)'(QDEPTH - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         count_ff <= count_ff + (QPW+1)'(push_valid) - (QPW+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/c3f_back.sv
// ----------------------------------------------------------------------------
// c3f_back
// Runs the kernel over one window: nine multiply-accumulate steps on all
// four channels, then one reciprocal multiply per channel, then output.
// ----------------------------------------------------------------------------
module c3f_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  c3f_pkg::win_entry_type q_entry,
   input  c3f_pkg::coeff_type     coeff,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_alpha,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue,
   output logic [11:0]            rsp_out_col,
   output logic [11:0]            rsp_out_row,
   output logic                   rsp_frame_last
);
   import c3f_pkg::*;

   back_state_type state_ff, state_in;
   win_entry_type  ent_ff;
   logic [3:0]     k_ff;
   logic [2:0]     sc_ff;
   logic signed [SUM_W-1:0]  acc_ff [CHANS];
   logic signed [PROD_W-1:0] prod_ff;
   logic [7:0]     res_ff [CHANS];
   logic           rsp_valid_ff;
   logic [7:0]     o_ch_ff [CHANS];
   logic [11:0]    o_col_ff, o_row_ff;
   logic           o_last_ff;
   logic           load, mac_step, scale_step, out_load, out_free;
   logic signed [15:0] tap;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tap      = tap_of(coeff, k_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (q_valid) state_in = B_MAC;
         B_MAC:   if (k_ff == 4'(TAPS - 1)) state_in = B_SCALE;
         B_SCALE: if (sc_ff == 3'(CHANS)) state_in = B_DONE;
         B_DONE:  if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      load       = 1'b0;
      mac_step   = 1'b0;
      scale_step = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         B_IDLE:  load       = q_valid;
         B_MAC:   mac_step   = 1'b1;
         B_SCALE: scale_step = 1'b1;
         B_DONE:  out_load   = out_free;
         default: ;
      endcase
   end

   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= q_entry;
         k_ff   <= '0;
         sc_ff  <= '0;
         for (int c = 0; c < CHANS; c++) begin
            acc_ff[c] <= '0;
         end
      end
      if (mac_step) begin
         k_ff <= k_ff + 4'd1;
         // channel 0 is alpha at the top byte
         for (int c = 0; c < CHANS; c++) begin
            acc_ff[c] <= acc_ff[c] + SUM_W'(tap * $signed({1'b0,
                         ent_ff.win[k_ff[3:0]][8*(CHANS-1-c) +: 8]}));
         end
      end
      if (scale_step) begin
         sc_ff <= sc_ff + 3'd1;
         if (sc_ff < 3'(CHANS)) begin
            prod_ff <= PROD_W'(acc_ff[sc_ff[1:0]] * $signed({1'b0, coeff.recip}));
         end
         if (sc_ff != 3'd0) begin
            res_ff[2'(sc_ff - 3'd1)] <= finish_chan(prod_ff, coeff.bias);
         end
      end
      if (out_load) begin
         for (int c = 0; c < CHANS; c++) begin
            o_ch_ff[c] <= res_ff[c];
         end
         o_col_ff  <= ent_ff.col;
         o_row_ff  <= ent_ff.row;
         o_last_ff <= ent_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_alpha  = o_ch_ff[0];
   assign rsp_out_red    = o_ch_ff[1];
   assign rsp_out_green  = o_ch_ff[2];
   assign rsp_out_blue   = o_ch_ff[3];
   assign rsp_out_col    = o_col_ff;
   assign rsp_out_row    = o_row_ff;
   assign rsp_frame_last = o_last_ff;

endmodule

### rtl/core/conv3x3_rgba_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_rgba_filter
// 3x3 convolution over a raster-order RGBA pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter one per clock while the window queue has room; each interior
// pixel's window then passes through the back end (one load from the
// queue, 9 MAC steps with one 16x8 multiplier per channel, 5 steps through
// the single shared 28x25 reciprocal multiplier, one output load), which
// takes no new window until the last one is out, so the four-entry queue
// absorbs bursts. Border pixels produce no result. The line stores need no
// clearing after reset.
module conv3x3_rgba_filter #(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_alpha,
   input  logic [7:0]  req_pixel_red,
   input  logic [7:0]  req_pixel_green,
   input  logic [7:0]  req_pixel_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_alpha,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [11:0] rsp_out_col,
   output logic [11:0] rsp_out_row,
   output logic        rsp_frame_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import c3f_pkg::*;

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned WW = (CW + 1 > 13) ? CW + 1 : 13;

   logic [12:0] width_ff, height_ff;
   logic [47:0] ctop_ff, cmid_ff, cbot_ff;
   logic [23:0] recip_ff;
   logic [9:0]  bias_ff;
   logic        csr_wr;
   logic [WW-1:0] width_lim;
   logic [12:0] height_lim;
   coeff_type   coeff;
   logic        q_almost_full, push_valid, q_valid, q_pop;
   win_entry_type push_entry, q_entry;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         ctop_ff   <= '0;
         cmid_ff   <= 48'h000001000000;
         cbot_ff   <= '0;
         recip_ff  <= 24'd65536;
         bias_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[5:3])
            REG_WIDTH:  width_ff  <= csr_pwdata[12:0];
            REG_HEIGHT: height_ff <= csr_pwdata[12:0];
            REG_CTOP:   ctop_ff   <= csr_pwdata[47:0];
            REG_CMID:   cmid_ff   <= csr_pwdata[47:0];
            REG_CBOT:   cbot_ff   <= csr_pwdata[47:0];
            REG_RECIP:  recip_ff  <= csr_pwdata[23:0];
            REG_BIAS:   bias_ff   <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         REG_WIDTH:  csr_prdata = {51'd0, width_ff};
         REG_HEIGHT: csr_prdata = {51'd0, height_ff};
         REG_CTOP:   csr_prdata = {16'd0, ctop_ff};
         REG_CMID:   csr_prdata = {16'd0, cmid_ff};
         REG_CBOT:   csr_prdata = {16'd0, cbot_ff};
         REG_RECIP:  csr_prdata = {40'd0, recip_ff};
         REG_BIAS:   csr_prdata = {54'd0, bias_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // clamp frame size to what the line stores and counters hold
   always_comb begin
      if (width_ff < 13'd3) begin
         width_lim = WW'(3);
      end else if (WW'(width_ff) > WW'(MAX_WIDTH)) begin
         width_lim = WW'(MAX_WIDTH);
      end else begin
         width_lim = WW'(width_ff);
      end
      if (height_ff < 13'd3) begin
         height_lim = 13'd3;
      end else if (height_ff > 13'd4096) begin
         height_lim = 13'd4096;
      end else begin
         height_lim = height_ff;
      end
   end

   assign coeff.top   = ctop_ff;
   assign coeff.mid   = cmid_ff;
   assign coeff.bot   = cbot_ff;
   assign coeff.recip = recip_ff;
   assign coeff.bias  = bias_ff;

   c3f_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     ({req_pixel_alpha, req_pixel_red, req_pixel_green, req_pixel_blue}),
      .width_lim     (width_lim),
      .height_lim    (height_lim),
      .q_almost_full (q_almost_full),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   c3f_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .almost_full (q_almost_full),
      .pop_valid   (q_valid),
      .pop         (q_pop),
      .pop_entry   (q_entry)
   );

   c3f_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_entry        (q_entry),
      .coeff          (coeff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

### rtl/core/c3f_checker.sv
// ----------------------------------------------------------------------------
// c3f_checker
// Port-level checks on the filter's result channel and register port.
// ----------------------------------------------------------------------------
module c3f_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_out_col,
   input logic [11:0] rsp_out_row,
   input logic [7:0]  rsp_out_red,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_col) && $stable(rsp_out_red))
      else $error("stalled result changed");

   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_col != 12'd0 && rsp_out_row != 12'd0)
      else $error("result on a border pixel");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("register port stalled");

endmodule

bind conv3x3_rgba_filter c3f_checker u_c3f_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for conv3x3_rgba_filter. Streams RGBA frames through the filter
// under several kernel, scale, bias and frame-size settings, predicts every
// filtered pixel and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module tb_top;
   import c3f_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int unsigned FRAME_MAX = 4096;
   localparam int unsigned TARGET_ITEMS = 1950;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam longint unsigned CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [7:0]  alpha;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] col;
      logic [11:0] row;
      logic        last;
   } filt_px_type;

   class filter_scoreboard;
      logic [31:0] store_prev[FRAME_MAX];
      logic [31:0] store_older[FRAME_MAX];
      logic [31:0] win[TAPS];
      int unsigned col_pos;
      int unsigned row_pos;
      logic [12:0] width_r;
      logic [12:0] height_r;
      logic [47:0] coeff_r[3];
      logic [23:0] recip_r;
      logic [9:0]  bias_r;
      filt_px_type exp_q[$];
      int unsigned errors;
      int unsigned matched;

      function new();
         foreach (store_prev[i]) begin
            store_prev[i] = '0;
            store_older[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col_pos = 0;
         row_pos = 0;
         width_r = 13'd640;
         height_r = 13'd480;
         coeff_r[0] = '0;
         coeff_r[1] = 48'h000001000000;
         coeff_r[2] = '0;
         recip_r = 24'd65536;
         bias_r = '0;
         errors = 0;
         matched = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            REG_WIDTH:  width_r = val[12:0];
            REG_HEIGHT: height_r = val[12:0];
            REG_CTOP:   coeff_r[0] = val[47:0];
            REG_CMID:   coeff_r[1] = val[47:0];
            REG_CBOT:   coeff_r[2] = val[47:0];
            REG_RECIP:  recip_r = val[23:0];
            REG_BIAS:   bias_r = val[9:0];
            default: ;
         endcase
      endfunction

      function int unsigned dim(logic [12:0] v);
         if (v < 3) return 3;
         if (v > FRAME_MAX) return FRAME_MAX;
         return v;
      endfunction

      function logic [7:0] filter_chan(int sh);
         longint acc;
         longint tap;
         longint prod;
         longint v;
         longint bv;
         acc = 0;
         for (int k = 0; k < TAPS; k++) begin
            tap = longint'($signed(coeff_r[k / 3][16 * (k % 3) +: 16]));
            acc += tap * longint'((win[k] >> sh) & 32'hFF);
         end
         prod = acc * longint'(recip_r);
         // truncate toward zero
         v = (prod >= 0) ? (prod >>> 24) : -((-prod) >>> 24);
         bv = longint'($signed(bias_r));
         v += bv;
         if (v > 255) v = 255;
         if (v < 0) v = 0;
         return v[7:0];
      endfunction

      function void note_pixel(logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int unsigned w;
         int unsigned h;
         logic [31:0] px;
         filt_px_type e;
         w = dim(width_r);
         h = dim(height_r);
         px = {a, r, g, b};
         for (int i = 0; i < 3; i++) begin
            win[i * 3] = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
         end
         win[2] = store_older[col_pos];
         win[5] = store_prev[col_pos];
         win[8] = px;
         store_older[col_pos] = store_prev[col_pos];
         store_prev[col_pos] = px;
         if (row_pos >= 2 && col_pos >= 2) begin
            e.alpha = filter_chan(24);
            e.red = filter_chan(16);
            e.green = filter_chan(8);
            e.blue = filter_chan(0);
            e.col = 12'(col_pos - 1);
            e.row = 12'(row_pos - 1);
            e.last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
            exp_q.push_back(e);
         end
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
      endfunction

      function void report(string what, longint got, longint want);
         errors++;
         $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      endfunction

      function void check_result(filt_px_type got);
         filt_px_type e;
         if (exp_q.size() == 0) begin
            report("unexpected transaction col", got.col, -1);
            return;
         end
         e = exp_q.pop_front();
         if (got.alpha !== e.alpha) report("alpha", got.alpha, e.alpha);
         if (got.red !== e.red) report("red", got.red, e.red);
         if (got.green !== e.green) report("green", got.green, e.green);
         if (got.blue !== e.blue) report("blue", got.blue, e.blue);
         if (got.col !== e.col) report("col", got.col, e.col);
         if (got.row !== e.row) report("row", got.row, e.row);
         if (got.last !== e.last) report("frame_last", got.last, e.last);
         matched++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_pixel_alpha;
   logic [7:0]  req_pixel_red;
   logic [7:0]  req_pixel_green;
   logic [7:0]  req_pixel_blue;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_alpha;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [11:0] rsp_out_col;
   logic [11:0] rsp_out_row;
   logic        rsp_frame_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   filter_scoreboard sb = new();
   int unsigned pixels_sent;
   int unsigned phase_count;
   int unsigned hold_len;
   bit          no_idle;
   longint unsigned cycles;

   conv3x3_rgba_filter u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned wt;
      filt_px_type got;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_len > 0) begin
            rsp_ready = 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         wt = no_idle ? 0 : $urandom_range(0, 8);
         if (wt > 0) begin
            rsp_ready = 1'b0;
            repeat (wt) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.alpha = rsp_out_alpha;
         got.red = rsp_out_red;
         got.green = rsp_out_green;
         got.blue = rsp_out_blue;
         got.col = rsp_out_col;
         got.row = rsp_out_row;
         got.last = rsp_frame_last;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_pixel(logic [31:0] px);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      {req_pixel_alpha, req_pixel_red, req_pixel_green, req_pixel_blue} = px;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(px[31:24], px[23:16], px[15:8], px[7:0]);
      pixels_sent++;
      @(negedge clock);
   endtask

   // bias toward byte extremes now and then
   function automatic logic [31:0] rand_pixel();
      logic [31:0] px;
      px = $urandom;
      for (int c = 0; c < 4; c++) begin
         case ($urandom_range(0, 7))
            0: px[8 * c +: 8] = 8'h00;
            1: px[8 * c +: 8] = 8'hFF;
            default: ;
         endcase
      end
      return px;
   endfunction

   function automatic logic [47:0] rand_taps(int mode);
      logic [47:0] row;
      row = 48'({$urandom, $urandom});
      if (mode == 1) begin
         for (int k = 0; k < 3; k++) row[16 * k +: 16] = 16'($urandom_range(0, 1024) - 512);
      end else if (mode == 2) begin
         row = {3{16'sd256}};
      end
      return row;
   endfunction

   // drain: wait for every expected pixel, then let the back end go quiet
   task automatic settle();
      req_valid = 1'b0;
      while (sb.exp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      phase_count++;
   endtask

   task automatic stream_frames(int unsigned nfr);
      int unsigned n;
      n = nfr * sb.dim(sb.width_r) * sb.dim(sb.height_r);
      repeat (n) send_pixel(rand_pixel());
      settle();
   endtask

   task automatic load_kernel(int mode, logic [23:0] recip, logic [9:0] bias);
      write_reg(REG_CTOP, 64'(rand_taps(mode)));
      write_reg(REG_CMID, 64'(rand_taps(mode)));
      write_reg(REG_CBOT, 64'(rand_taps(mode)));
      write_reg(REG_RECIP, 64'(recip));
      write_reg(REG_BIAS, 64'(bias));
   endtask

   initial begin
      logic [7:0] lvl[6];
      int mode;
      lvl = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_alpha = '0;
      req_pixel_red = '0;
      req_pixel_green = '0;
      req_pixel_blue = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      pixels_sent = 0;
      phase_count = 0;
      hold_len = 0;
      no_idle = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: identity kernel from reset on a 5x5 frame of fixed levels, extremes among them
      write_reg(REG_WIDTH, 64'd5);
      write_reg(REG_HEIGHT, 64'd5);
      for (int k = 0; k < 25; k++) begin
         send_pixel({lvl[k % 6], lvl[(k + 1) % 6], lvl[(k + 2) % 6], lvl[(k + 3) % 6]});
      end
      settle();

      // zero scale with top bias, full scale with bottom bias, then most-negative taps
      write_reg(REG_WIDTH, 64'd6);
      load_kernel(0, 24'd0, 10'sd511);
      stream_frames(1);
      write_reg(REG_CTOP, 64'({3{16'h7FFF}}));
      write_reg(REG_CMID, 64'({3{16'h7FFF}}));
      write_reg(REG_CBOT, 64'({3{16'h7FFF}}));
      write_reg(REG_RECIP, 64'(24'hFFFFFF));
      write_reg(REG_BIAS, 64'(10'h200));
      stream_frames(1);
      write_reg(REG_CTOP, 64'({3{16'h8000}}));
      write_reg(REG_CMID, 64'({3{16'h8000}}));
      write_reg(REG_CBOT, 64'({3{16'h8000}}));
      write_reg(REG_BIAS, 64'(10'd0));
      stream_frames(1);

      // sizes below range clamp to 3x3; unused index is ignored
      write_reg(REG_WIDTH, 64'd0);
      write_reg(REG_HEIGHT, 64'd0);
      write_reg(REG_UNUSED, {$urandom, $urandom});
      load_kernel(1, 24'd7282, 10'd0);
      stream_frames(2);

      // wide frame; height below range clamps to 3; the output is held off
      // long enough for the queue to fill and stall the input
      write_reg(REG_WIDTH, 64'd100);
      write_reg(REG_HEIGHT, 64'd2);
      load_kernel(2, 24'd7282, 10'd0);
      hold_len = 400;
      stream_frames(1);

      // random frames until the item budget is spent
      while (pixels_sent < TARGET_ITEMS) begin
         mode = $urandom_range(0, 3);
         write_reg(REG_WIDTH, 64'($urandom_range(3, 14)));
         write_reg(REG_HEIGHT, 64'($urandom_range(3, 8)));
         load_kernel(mode, (mode == 0) ? 24'($urandom) : 24'($urandom_range(0, 70000)),
                     ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40) - 20));
         no_idle = ($urandom_range(0, 3) == 0);
         stream_frames($urandom_range(1, 2));
      end

      $display("Covered %0d frame phases; %0d filtered pixels checked, %0d mismatches.",
               phase_count, sb.matched, sb.errors);
      $display("Included clamp, scale/bias extremes, a wide frame and output back-pressure.");
      if (sb.errors == 0 && sb.exp_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
